[hdl/rsfe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsfe_pkg: shared types and constants of the RGB status fade engine
// Request payloads, lane command bundle, field widths and register indexes.
// ----------------------------------------------------------------------------
package rsfe_pkg;

  // Field and state widths
  localparam int LEVEL_W   = 16;
  localparam int STEP_W    = 16;
  localparam int GOAL_W    = 8;
  localparam int GAIN_W    = 8;
  localparam int RATE_W    = 8;
  localparam int MASK_W    = 3;
  localparam int SCL_W     = 9;   // (level * gain) >> 15 never exceeds 509
  localparam int DUTY_W    = 10;
  localparam int NUM_LANES = 3;
  localparam int CFG_IDX_W = 2;

  // Override level for a forced-on channel
  localparam logic [LEVEL_W-1:0] LVL_FULL = 16'hff00;

  // Request function codes
  localparam logic FUNC_SET  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_RED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_GREEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_BLUE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW = 2'd3;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd255;

  typedef struct packed {
    logic              func;
    logic [GOAL_W-1:0] target_red;
    logic [GOAL_W-1:0] target_green;
    logic [GOAL_W-1:0] target_blue;
    logic [RATE_W-1:0] fade_rate;
    logic [MASK_W-1:0] override_mask;
  } in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_red;
    logic [DUTY_W-1:0] duty_green;
    logic [DUTY_W-1:0] duty_blue;
    logic              any_lit;
  } out_t;

  // Command broadcast to every lane
  typedef struct packed {
    logic              upd;
    logic              func;
    logic [RATE_W-1:0] rate;
  } lane_cmd_t;

endpackage
`default_nettype wire

[hdl/rsfe_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsfe_lane: one color channel of the fade engine
// Holds level, step and goal; applies set and tick requests; forms the
// scaled brightness from the registered level, override and gain.
// ----------------------------------------------------------------------------
module rsfe_lane import rsfe_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lane_cmd_t         cmd,
  input  wire logic [GOAL_W-1:0] target,
  input  wire logic              ovr_en,
  input  wire logic              ovr_bit,
  input  wire logic [GAIN_W-1:0] gain,
  output logic      [SCL_W-1:0]  scaled
);

  logic        [LEVEL_W-1:0] level_r, level_nxt;
  logic signed [STEP_W-1:0]  step_r, step_nxt;
  logic        [GOAL_W-1:0]  goal_r, goal_nxt;

  logic signed [GOAL_W:0]    diff;
  logic signed [2*GOAL_W+1:0] sprod;
  logic signed [LEVEL_W+1:0] sum_v;
  logic        [LEVEL_W-GOAL_W+1:0] hi;
  logic                      snap;
  logic        [LEVEL_W-1:0] lvl_sel;
  logic        [LEVEL_W+GAIN_W-1:0] gprod;

  // Set path: step = floor((target - level_hi) * rate / 2)
  assign diff  = $signed({1'b0, target}) - $signed({1'b0, level_r[LEVEL_W-1:GOAL_W]});
  assign sprod = diff * $signed({1'b0, cmd.rate});

  // Tick path: advance level, snap on zero step or when passing the goal
  assign sum_v = $signed({2'b00, level_r}) + $signed({{2{step_r[STEP_W-1]}}, step_r});
  assign hi    = sum_v[LEVEL_W+1:GOAL_W];
  always_comb begin
    if (step_r == '0) begin
      snap = 1'b1;
    end else if (step_r[STEP_W-1]) begin
      snap = sum_v[LEVEL_W+1] || (hi < {2'b00, goal_r});
    end else begin
      snap = hi > {2'b00, goal_r};
    end
  end

  always_comb begin
    level_nxt = level_r;
    step_nxt  = step_r;
    goal_nxt  = goal_r;
    if (cmd.upd) begin
      if (cmd.func == FUNC_SET) begin
        goal_nxt = target;
        step_nxt = sprod[STEP_W:1];
      end else if (snap) begin
        step_nxt  = '0;
        level_nxt = {goal_r, {(LEVEL_W-GOAL_W){1'b0}}};
      end else begin
        level_nxt = sum_v[LEVEL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      step_r  <= '0;
      goal_r  <= '0;
    end else begin
      level_r <= level_nxt;
      step_r  <= step_nxt;
      goal_r  <= goal_nxt;
    end
  end

  // Scale the (possibly overridden) level by the channel gain
  always_comb begin
    if (ovr_en) begin
      lvl_sel = ovr_bit ? LVL_FULL : '0;
    end else begin
      lvl_sel = level_r;
    end
  end
  assign gprod  = lvl_sel * gain;
  assign scaled = gprod[LEVEL_W+GAIN_W-1:LEVEL_W+GAIN_W-SCL_W];

endmodule
`default_nettype wire

[hdl/rsfe_merge.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsfe_merge: combine lane results into the output request
// Converts scaled values to PWM duties, forms any_lit, holds the output
// register and its valid flag.
// ----------------------------------------------------------------------------
module rsfe_merge import rsfe_pkg::*; #(
  parameter int DUTY_PERIOD = 512
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             advance,
  input  wire logic             s1_valid,
  input  wire logic             active_low,
  input  wire logic [SCL_W-1:0] scaled [NUM_LANES],
  output logic                  out_valid_r,
  output out_t                  out_data_r
);

  localparam int PW = $clog2(DUTY_PERIOD + 1);
  localparam logic [PW-1:0] PERIOD   = PW'(DUTY_PERIOD);
  localparam logic [PW-1:0] PERIOD_M = PW'(DUTY_PERIOD - 1);

  logic [PW-1:0]     scl_x [NUM_LANES];
  logic [DUTY_W-1:0] duty  [NUM_LANES];
  logic              lit;
  out_t              out_data_nxt;
  logic              out_valid_nxt;

  // Clamp for active-high drive, invert and floor for active-low drive
  for (genvar i = 0; i < NUM_LANES; i++) begin : g_duty
    logic [PW-1:0] d;
    assign scl_x[i] = PW'(scaled[i]);
    always_comb begin
      if (!active_low) begin
        d = (scl_x[i] >= PERIOD) ? PERIOD_M : scl_x[i];
      end else begin
        d = (scl_x[i] > PERIOD) ? '0 : PERIOD - scl_x[i];
      end
    end
    assign duty[i] = d[DUTY_W-1:0];
  end

  assign lit = (scaled[0] != '0) || (scaled[1] != '0) || (scaled[2] != '0);

  always_comb begin
    out_data_nxt            = out_data_r;
    out_valid_nxt           = out_valid_r;
    if (advance) begin
      out_valid_nxt           = s1_valid;
      out_data_nxt.duty_red   = duty[0];
      out_data_nxt.duty_green = duty[1];
      out_data_nxt.duty_blue  = duty[2];
      out_data_nxt.any_lit    = lit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload register needs no reset
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

[hdl/rgb_status_fade_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_status_fade_engine: three-channel RGB status LED fader
// Set requests load fade targets and steps, tick requests advance the fade;
// every request yields one result with PWM duties and an any-lit flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input (in_valid/in_ready/in_data) takes one request per cycle if ready.
//   func selects set (load targets, compute step) or tick (advance levels).
//   Result channel (out_valid/out_ready/out_data) returns one result per
//   request in order, duties computed from the levels after the update.
//   Path: an accepted request updates the lanes and stage 1; the output
//   register captures its duties when the pipeline advances. Throughput:
//   one request per cycle unless stalled, set by lane update and gain multiply.
//   The fade state sits in the lanes and updates at the accept edge; a
//   second register stage forms the duties and holds them on the output.
//   A stalled receiver freezes both stages and deasserts in_ready.
//   Configuration (cfg_we/cfg_idx/cfg_wdata) writes gains and active-low
//   drive; write only while no request is in flight.
//   Reset (rst_n low, synchronous) clears levels, steps and goals, sets all
//   gains to 255, active-high drive, and empties the pipeline.
// ----------------------------------------------------------------------------
module rgb_status_fade_engine import rsfe_pkg::*; #(
  parameter int DUTY_PERIOD = 512
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_t                  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_t                      out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [GAIN_W-1:0]    cfg_wdata
);

  logic [GAIN_W-1:0] gain_r [NUM_LANES];
  logic [GAIN_W-1:0] gain_nxt [NUM_LANES];
  logic              active_low_r, active_low_nxt;
  logic              s1_valid_r, s1_valid_nxt;
  logic [MASK_W-1:0] s1_mask_r, s1_mask_nxt;
  logic              advance;
  logic              accept;
  lane_cmd_t         cmd;
  logic [GOAL_W-1:0] tgt [NUM_LANES];
  logic [SCL_W-1:0]  scaled [NUM_LANES];
  logic              out_valid_r;
  out_t              out_data_r;

  // Pipeline moves whenever the output register is free or being drained
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = advance;
  assign accept   = in_valid && in_ready;

  // Configuration registers
  always_comb begin
    gain_nxt       = gain_r;
    active_low_nxt = active_low_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_GAIN_RED:   gain_nxt[0]    = cfg_wdata;
        CFG_GAIN_GREEN: gain_nxt[1]    = cfg_wdata;
        CFG_GAIN_BLUE:  gain_nxt[2]    = cfg_wdata;
        CFG_ACTIVE_LOW: active_low_nxt = cfg_wdata[0];
        default:        active_low_nxt = active_low_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r       <= '{default: GAIN_RESET};
      active_low_r <= 1'b0;
    end else begin
      gain_r       <= gain_nxt;
      active_low_r <= active_low_nxt;
    end
  end

  // Stage 1: hold the override mask of the request whose update just landed
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_mask_nxt  = s1_mask_r;
    if (advance) begin
      s1_valid_nxt = accept;
      s1_mask_nxt  = in_data.override_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_mask_r <= s1_mask_nxt;
  end

  // Broadcast the request to the lanes
  assign cmd.upd  = accept;
  assign cmd.func = in_data.func;
  assign cmd.rate = in_data.fade_rate;
  assign tgt[0]   = in_data.target_red;
  assign tgt[1]   = in_data.target_green;
  assign tgt[2]   = in_data.target_blue;

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    rsfe_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .target  (tgt[i]),
      .ovr_en  (s1_mask_r != '0),
      .ovr_bit (s1_mask_r[i]),
      .gain    (gain_r[i]),
      .scaled  (scaled[i])
    );
  end

  rsfe_merge #(
    .DUTY_PERIOD (DUTY_PERIOD)
  ) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .s1_valid    (s1_valid_r),
    .active_low  (active_low_r),
    .scaled      (scaled),
    .out_valid_r (out_valid_r),
    .out_data_r  (out_data_r)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Accepted request lands in stage 1
  a_accept_s1: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted request did not reach stage 1");

  // Stage 1 request is kept while the pipeline stalls
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_mask_r))
    else $error("stage 1 request lost during stall");

  // Stage 1 request moves to the output register when the pipeline advances
  a_s1_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && advance |=> out_valid_r)
    else $error("stage 1 request did not reach the output");

endmodule
`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the RGB status fade engine
// Drives set and tick requests with random gaps and result-side stalls,
// predicts levels, steps and PWM duties in a scoreboard, compares every result.
// ----------------------------------------------------------------------------
module tb;
  import rsfe_pkg::*;

  localparam int PERIOD      = 512;
  localparam int CYCLE_LIMIT = 200000;

  // Fade predictor and in-order store of expected duties
  class fade_scoreboard;
    logic [GAIN_W-1:0]  gain [NUM_LANES];
    bit                 active_low;
    logic [LEVEL_W-1:0] level [NUM_LANES];
    int                 frame_step [NUM_LANES];
    logic [GOAL_W-1:0]  goal [NUM_LANES];
    out_t               duty_queue [$];
    int                 errors;

    function void clear();
      for (int i = 0; i < NUM_LANES; i++) begin
        gain[i]       = GAIN_RESET;
        level[i]      = '0;
        frame_step[i] = 0;
        goal[i]       = '0;
      end
      active_low = 1'b0;
      duty_queue.delete();
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
      case (idx)
        CFG_GAIN_RED:   gain[0] = val;
        CFG_GAIN_GREEN: gain[1] = val;
        CFG_GAIN_BLUE:  gain[2] = val;
        CFG_ACTIVE_LOW: active_low = val[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return duty_queue.size();
    endfunction

    // Update fade state for one accepted request and queue its duties
    function void note_request(in_t req);
      logic [GOAL_W-1:0]  tgt [NUM_LANES];
      logic [LEVEL_W-1:0] lvl;
      logic [DUTY_W-1:0]  duty [NUM_LANES];
      int diff, v, hi, scaled, d, sum;
      out_t want;
      tgt[0] = req.target_red;
      tgt[1] = req.target_green;
      tgt[2] = req.target_blue;
      sum = 0;
      for (int i = 0; i < NUM_LANES; i++) begin
        if (req.func == FUNC_SET) begin
          diff = int'(tgt[i]) - int'(level[i][15:8]);
          goal[i] = tgt[i];
          frame_step[i] = (diff * int'(req.fade_rate)) >>> 1;
        end else begin
          v  = int'(level[i]) + frame_step[i];
          hi = (v < 0) ? -1 : (v >>> 8);
          // snap to goal on zero step, overshoot or undershoot
          if (frame_step[i] == 0 || (frame_step[i] < 0 && hi < int'(goal[i])) ||
              (frame_step[i] > 0 && hi > int'(goal[i]))) begin
            frame_step[i] = 0;
            level[i] = {goal[i], 8'h00};
          end else begin
            level[i] = v[15:0];
          end
        end
      end
      // Scale by gain, then clamp or invert
      for (int i = 0; i < NUM_LANES; i++) begin
        lvl = level[i];
        if (req.override_mask != '0)
          lvl = req.override_mask[i] ? LVL_FULL : '0;
        scaled = (int'(lvl) * int'(gain[i])) >>> 15;
        sum += scaled;
        if (!active_low) begin
          d = (scaled >= PERIOD) ? PERIOD - 1 : scaled;
        end else begin
          d = PERIOD - scaled;
          if (d < 0)
            d = 0;
        end
        duty[i] = d[DUTY_W-1:0];
      end
      want.duty_red   = duty[0];
      want.duty_green = duty[1];
      want.duty_blue  = duty[2];
      want.any_lit    = (sum != 0);
      duty_queue.push_back(want);
    endfunction

    function void field_check(string name, logic [DUTY_W-1:0] want, logic [DUTY_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(out_t got);
      out_t want;
      if (duty_queue.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = duty_queue.pop_front();
      field_check("duty_red", want.duty_red, got.duty_red);
      field_check("duty_green", want.duty_green, got.duty_green);
      field_check("duty_blue", want.duty_blue, got.duty_blue);
      field_check("any_lit", DUTY_W'(want.any_lit), DUTY_W'(got.any_lit));
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  out_t                 out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [GAIN_W-1:0]    cfg_wdata = '0;

  fade_scoreboard sb = new();
  int unsigned    idle_max = 4;
  int unsigned    cycle_count = 0;

  rgb_status_fade_engine #(.DUTY_PERIOD(PERIOD)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Bound the run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Accept results with random stalls
  initial begin
    int unsigned stall;
    forever begin
      stall = $urandom_range(0, idle_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_ready <= 1'b1;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_result(out_data);
    end
  end

  function automatic in_t make_req(logic func, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                   logic [7:0] rate, logic [2:0] mask);
    in_t req;
    req.func          = func;
    req.target_red    = r;
    req.target_green  = g;
    req.target_blue   = b;
    req.fade_rate     = rate;
    req.override_mask = mask;
    return req;
  endfunction

  // Present one request after a random gap and hold it until accepted
  task automatic send_request(in_t req);
    int unsigned gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_request(req);
  endtask

  // Drop valid and wait for every expected result
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_config(logic [7:0] gr, logic [7:0] gg, logic [7:0] gb, logic al);
    logic [GAIN_W-1:0] vals [4];
    logic [CFG_IDX_W-1:0] idxs [4];
    vals = '{gr, gg, gb, {7'd0, al}};
    idxs = '{CFG_GAIN_RED, CFG_GAIN_GREEN, CFG_GAIN_BLUE, CFG_ACTIVE_LOW};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idxs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.write_reg(idxs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [2:0] rand_mask();
    return ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd0;
  endfunction

  // Mostly set-then-ticks sequences, some free noise
  task automatic run_random(int n_items);
    int sent, ticks;
    logic [7:0] rate;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        rate = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 12));
        send_request(make_req(FUNC_SET, 8'($urandom), 8'($urandom), 8'($urandom),
                              rate, rand_mask()));
        ticks = $urandom_range(1, 10);
        for (int k = 0; k < ticks; k++)
          send_request(make_req(FUNC_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
                                8'($urandom), rand_mask()));
        sent += ticks + 1;
      end else begin
        send_request(make_req(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                              8'($urandom), 3'($urandom)));
        sent++;
      end
    end
  endtask

  initial begin
    sb.clear();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset state, jumps, fades with overshoot and undershoot
    send_request(make_req(FUNC_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0));
    send_request(make_req(FUNC_SET, 8'd255, 8'd128, 8'd0, 8'd0, 3'd0));
    send_request(make_req(FUNC_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0));
    send_request(make_req(FUNC_SET, 8'd0, 8'd0, 8'd0, 8'd255, 3'd7));
    send_request(make_req(FUNC_TICK, 8'd255, 8'd255, 8'd255, 8'd255, 3'd0));
    send_request(make_req(FUNC_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0));
    send_request(make_req(FUNC_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0));
    send_request(make_req(FUNC_SET, 8'd255, 8'd255, 8'd255, 8'd255, 3'd1));
    send_request(make_req(FUNC_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 3'd2));
    send_request(make_req(FUNC_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 3'd4));
    send_request(make_req(FUNC_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0));
    // odd negative product floors away from zero
    send_request(make_req(FUNC_SET, 8'd4, 8'd4, 8'd4, 8'd1, 3'd0));
    send_request(make_req(FUNC_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0));
    send_request(make_req(FUNC_SET, 8'd254, 8'd1, 8'd128, 8'd3, 3'd5));
    for (int k = 0; k < 3; k++)
      send_request(make_req(FUNC_TICK, 8'd255, 8'd255, 8'd255, 8'd255, 3'd0));
    send_request(make_req(FUNC_SET, 8'd0, 8'd255, 8'd0, 8'd128, 3'd6));
    for (int k = 0; k < 3; k++)
      send_request(make_req(FUNC_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 3'd3));
    wait_idle();

    // Random phases over several register settings
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: apply_config(8'd0, 8'd0, 8'd0, 1'b0);
        1: apply_config(8'd255, 8'd255, 8'd255, 1'b1);
        2: apply_config(8'd0, 8'd0, 8'd0, 1'b1);
        4: apply_config(8'd255, 8'd255, 8'd255, 1'b0);
        default: apply_config(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      endcase
      idle_max = (p == 4) ? 0 : 4;
      run_random(60);
      // hold off until the result side has caught up
      if (p == 3)
        wait_idle();
      run_random(55);
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
